/* src/tsjt_pkg.sv */
// Package for the time-sorted job table: sizes, status and request codes,
// cell commands and the entry type. It depends on nothing else.
package tsjt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int TIME_W = 31;
    localparam int SER_W = 31;

    localparam logic [TIME_W-1:0] NONE_TIME = {TIME_W{1'b1}};

    localparam logic REQ_OPEN = 1'b0;
    localparam logic REQ_CLOSE = 1'b1;

    localparam logic [1:0] ST_OPENED = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_CLOSED = 2'd2;
    localparam logic [1:0] ST_MISSING = 2'd3;

    localparam logic [1:0] CMD_HOLD = 2'd0;
    localparam logic [1:0] CMD_LOAD_NEW = 2'd1;
    localparam logic [1:0] CMD_FROM_PREV = 2'd2;
    localparam logic [1:0] CMD_FROM_NEXT = 2'd3;

    typedef struct packed {
        logic [TIME_W-1:0] job_time;
        logic [SER_W-1:0] job_serial;
    } entry_t;

endpackage

/* src/tsjt_ifs.sv */
// Valid/ready channel interfaces for requests and results of the job table.
// Depends on tsjt_pkg for the field widths.
interface tsjt_req_if
    import tsjt_pkg::*;
();
    logic valid;
    logic ready;
    logic req_type;
    logic [TIME_W-1:0] job_time;
    logic [SER_W-1:0] job_serial;

    modport source (output valid, output req_type, output job_time, output job_serial,
                    input ready);
    modport sink (input valid, input req_type, input job_time, input job_serial,
                  output ready);
endinterface

interface tsjt_rsp_if
    import tsjt_pkg::*;
();
    logic valid;
    logic ready;
    logic [1:0] status;
    logic [TIME_W-1:0] closed_time;

    modport source (output valid, output status, output closed_time, input ready);
    modport sink (input valid, input status, input closed_time, output ready);
endinterface

/* src/tsjt_cell.sv */
// One slot of the sorted job chain: holds an entry, compares it with the
// incoming request and loads from itself, the request or a neighbor. Uses tsjt_pkg.
module tsjt_cell
    import tsjt_pkg::*;
(
    input  logic clk,
    input  logic [1:0] cmd,
    input  entry_t new_ent,
    input  entry_t prev_ent,
    input  entry_t next_ent,
    input  logic [TIME_W-1:0] cmp_time,
    input  logic [SER_W-1:0] cmp_serial,
    output entry_t ent,
    output logic le,
    output logic hit
);

    entry_t ent_reg;
    entry_t ent_next;

    always_comb
    begin
        unique case (cmd)
            CMD_HOLD:      ent_next = ent_reg;
            CMD_LOAD_NEW:  ent_next = new_ent;
            CMD_FROM_PREV: ent_next = prev_ent;
            CMD_FROM_NEXT: ent_next = next_ent;
            default:       ent_next = ent_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

    assign ent = ent_reg;
    assign le = (ent_reg.job_time <= cmp_time);
    assign hit = (ent_reg.job_serial == cmp_serial);

endmodule

/* src/time_sorted_job_table.sv */
// Time-sorted job table: a chain of TABLE_DEPTH cells kept in ascending time order.
// Each transaction compares in the accept cycle, then shifts in the update state.
// A new request is taken only once the update is done; the result register lets the next
// request be taken while a result waits, and a full result register stalls the shift.
// Reset clears the entry count, the control state and the result valid flag.
module time_sorted_job_table
    import tsjt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    tsjt_req_if.sink req,
    tsjt_rsp_if.source rsp
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_UPD = 1'b1;

    logic state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [TABLE_DEPTH-1:0] le_reg, hit_reg;
    logic op_type_reg;
    entry_t op_ent_reg;
    logic out_valid_reg;
    logic [1:0] status_reg, status_next;
    logic [TIME_W-1:0] ctime_reg, ctime_next;

    entry_t ents [TABLE_DEPTH];
    entry_t prevs [TABLE_DEPTH];
    entry_t nexts [TABLE_DEPTH];
    logic [1:0] cmds [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] les, hits, occ, le_prev;
    logic [TABLE_DEPTH-1:0] first_hit, below_hit;
    logic in_fire, upd_fire, full, found;
    logic [TIME_W-1:0] sel_time;

    assign req.ready = (state_reg == S_IDLE);
    assign in_fire = req.valid && req.ready;
    assign upd_fire = (state_reg == S_UPD) && (!out_valid_reg || rsp.ready);

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++)
        begin : g_cell
            assign occ[g] = (count_reg > CNT_W'(g));

            if (g == 0)
            begin : g_first
                assign prevs[g] = ents[g];
                assign le_prev[g] = 1'b1;
            end
            else
            begin : g_mid
                assign prevs[g] = ents[g-1];
                assign le_prev[g] = le_reg[g-1];
            end

            if (g == TABLE_DEPTH - 1)
            begin : g_last
                assign nexts[g] = ents[g];
            end
            else
            begin : g_inner
                assign nexts[g] = ents[g+1];
            end

            tsjt_cell u_cell (
                .clk        (clk),
                .cmd        (cmds[g]),
                .new_ent    (op_ent_reg),
                .prev_ent   (prevs[g]),
                .next_ent   (nexts[g]),
                .cmp_time   (req.job_time),
                .cmp_serial (req.job_serial),
                .ent        (ents[g]),
                .le         (les[g]),
                .hit        (hits[g])
            );
        end
    endgenerate

    // The lowest set hit marks the first match in time order; cells at or
    // above it take their upper neighbor.
    assign first_hit = hit_reg & ~(hit_reg - TABLE_DEPTH'(1));
    assign below_hit = (hit_reg - TABLE_DEPTH'(1)) & ~hit_reg;
    assign found = |hit_reg;
    assign full = (count_reg == CNT_W'(TABLE_DEPTH));

    always_comb
    begin
        sel_time = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            sel_time = sel_time | (ents[i].job_time & {TIME_W{first_hit[i]}});
        end
    end

    always_comb
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            cmds[i] = CMD_HOLD;
            if (upd_fire && op_type_reg == REQ_OPEN && !full)
            begin
                if (le_reg[i])
                    cmds[i] = CMD_HOLD;
                else if (le_prev[i])
                    cmds[i] = CMD_LOAD_NEW;
                else
                    cmds[i] = CMD_FROM_PREV;
            end
            else if (upd_fire && op_type_reg == REQ_CLOSE && found)
            begin
                cmds[i] = below_hit[i] ? CMD_HOLD : CMD_FROM_NEXT;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        status_next = status_reg;
        ctime_next = ctime_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                    state_next = S_UPD;
            end
            S_UPD:
            begin
                if (upd_fire)
                begin
                    state_next = S_IDLE;
                    ctime_next = NONE_TIME;
                    if (op_type_reg == REQ_OPEN)
                    begin
                        if (full)
                            status_next = ST_FULL;
                        else
                        begin
                            status_next = ST_OPENED;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    else if (found)
                    begin
                        status_next = ST_CLOSED;
                        ctime_next = sel_time;
                        count_next = count_reg - CNT_W'(1);
                    end
                    else
                        status_next = ST_MISSING;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (upd_fire)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        ctime_reg <= ctime_next;
        if (in_fire)
        begin
            op_type_reg <= req.req_type;
            op_ent_reg.job_time <= req.job_time;
            op_ent_reg.job_serial <= req.job_serial;
            le_reg <= les & occ;
            // Serial zero never matches a stored job.
            hit_reg <= hits & occ & {TABLE_DEPTH{req.job_serial != '0}};
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.status = status_reg;
    assign rsp.closed_time = ctime_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count exceeds table depth");

    a_open_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (upd_fire && status_next == ST_OPENED) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("open did not add an entry");

    a_close_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (upd_fire && status_next == ST_CLOSED) |=> count_reg == $past(count_reg) - 1'b1)
        else $error("close did not remove an entry");

    a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPD) |-> $onehot0(first_hit))
        else $error("more than one entry selected for removal");
`endif

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for time_sorted_job_table: directed and random open/close
// traffic with a sorted-table predictor. Depends on tsjt_pkg, tsjt_ifs and the RTL.
module tb;
    import tsjt_pkg::*;

    localparam int HOLD_CYCLES = 80;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 16;

    typedef struct {
        logic [1:0] status;
        logic [TIME_W-1:0] closed_time;
    } reply_t;

    logic clk;
    logic rst_n;

    tsjt_req_if req_ch();
    tsjt_rsp_if rsp_ch();

    time_sorted_job_table DUT (
        .clk(clk),
        .rst_n(rst_n),
        .req(req_ch),
        .rsp(rsp_ch)
    );

    entry_t model_jobs[$];
    reply_t awaited_replies[$];
    logic [SER_W-1:0] open_serials[$];

    int error_count = 0;
    int idle_cycles = 0;
    bit idle_enable = 1'b1;
    int burst_left = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;
    int pattern_mode = 0;
    int pattern_left = 0;

    initial begin
        clk = 1'b0;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.req_type = REQ_OPEN;
        req_ch.job_time = '0;
        req_ch.job_serial = '0;
        rsp_ch.ready = 1'b0;
    end

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Sorted insert after equal times; close removes the first serial match in time order.
    function automatic reply_t apply_job_request(input logic rtype,
                                                 input logic [TIME_W-1:0] t,
                                                 input logic [SER_W-1:0] s);
        reply_t res;
        entry_t slot;
        int pos;
        res.status = ST_MISSING;
        res.closed_time = NONE_TIME;
        if (rtype == REQ_OPEN) begin
            if (model_jobs.size() >= TABLE_DEPTH) begin
                res.status = ST_FULL;
            end
            else begin
                pos = 0;
                while (pos < model_jobs.size() && model_jobs[pos].job_time <= t)
                    pos++;
                slot.job_time = t;
                slot.job_serial = s;
                model_jobs.insert(pos, slot);
                res.status = ST_OPENED;
            end
        end
        else if (s != '0) begin
            for (pos = 0; pos < model_jobs.size(); pos++) begin
                if (model_jobs[pos].job_serial == s)
                    break;
            end
            if (pos < model_jobs.size()) begin
                res.status = ST_CLOSED;
                res.closed_time = model_jobs[pos].job_time;
                model_jobs.delete(pos);
            end
        end
        return res;
    endfunction

    task automatic note_error(input string msg);
        if (error_count < 10)
            $display("%s", msg);
        error_count++;
    endtask

    // Results are checked before the request of the same edge is predicted.
    always @(posedge clk)
    begin
        reply_t want;
        if (rst_n) begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (awaited_replies.size() == 0) begin
                    note_error($sformatf("Unexpected result: status %0d closed_time %0d",
                                         rsp_ch.status, rsp_ch.closed_time));
                end
                else begin
                    want = awaited_replies.pop_front();
                    if (rsp_ch.status !== want.status)
                        note_error($sformatf("status mismatch: expected %0d, got %0d",
                                             want.status, rsp_ch.status));
                    if (rsp_ch.closed_time !== want.closed_time)
                        note_error($sformatf("closed_time mismatch: expected %0d, got %0d",
                                             want.closed_time, rsp_ch.closed_time));
                end
            end
            if (req_ch.valid && req_ch.ready)
                awaited_replies.push_back(apply_job_request(req_ch.req_type, req_ch.job_time,
                                                            req_ch.job_serial));
        end
    end

    // Result-side flow control: a long hold on request, else always ready or a stall pattern.
    always @(posedge clk)
    begin
        if (!rst_n) begin
            rsp_ch.ready <= 1'b0;
        end
        else if (hold_left != 0 || hold_served != hold_requests) begin
            if (hold_left == 0) begin
                hold_left = HOLD_CYCLES;
                hold_served++;
            end
            else begin
                hold_left--;
            end
            rsp_ch.ready <= 1'b0;
        end
        else if (!idle_enable) begin
            rsp_ch.ready <= 1'b1;
        end
        else begin
            if (pattern_left == 0) begin
                pattern_mode = $urandom_range(0, 3);
                pattern_left = $urandom_range(8, 64);
            end
            else begin
                pattern_left--;
            end
            case (pattern_mode)
                0: rsp_ch.ready <= 1'b1;
                1: rsp_ch.ready <= 1'($urandom_range(0, 1));
                2: rsp_ch.ready <= (pattern_left % 4 == 0);
                default: rsp_ch.ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Offers one request and returns once it is accepted, after an idle gap when a burst ends.
    task automatic send_request(input logic rtype, input logic [TIME_W-1:0] t,
                                input logic [SER_W-1:0] s);
        int gap;
        req_ch.valid <= 1'b1;
        req_ch.req_type <= rtype;
        req_ch.job_time <= t;
        req_ch.job_serial <= s;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        if (idle_enable) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap = $urandom_range(1, 9);
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            else begin
                burst_left--;
            end
        end
    endtask

    task automatic issue_open(input logic [TIME_W-1:0] t, input logic [SER_W-1:0] s);
        send_request(REQ_OPEN, t, s);
        if (s != '0)
            open_serials.push_back(s);
    endtask

    task automatic issue_close(input logic [SER_W-1:0] s);
        int idx;
        send_request(REQ_CLOSE, TIME_W'($urandom), s);
        for (idx = 0; idx < open_serials.size(); idx++) begin
            if (open_serials[idx] == s) begin
                open_serials.delete(idx);
                break;
            end
        end
    endtask

    task automatic wait_all_results();
        req_ch.valid <= 1'b0;
        while (awaited_replies.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_empty_table();
        issue_close(SER_W'(7));
        issue_close('0);
    endtask

    task automatic test_order_and_ties();
        issue_open(TIME_W'(100), SER_W'(7));
        issue_open(TIME_W'(100), SER_W'(8));
        issue_open('0, {SER_W{1'b1}});
        issue_open(NONE_TIME, SER_W'(9));
        issue_open(TIME_W'(50), SER_W'(7));
        issue_open(TIME_W'(31'h2AAAAAAA), SER_W'(31'h55555555));
        issue_open(TIME_W'(31'h55555555), SER_W'(31'h2AAAAAAA));
        // A job with serial zero can never be closed, so it holds its slot from here on.
        issue_open(TIME_W'(200), '0);
    endtask

    task automatic test_full_table();
        int i;
        for (i = 0; i < 8; i++)
            issue_open(TIME_W'($urandom), SER_W'(100 + i));
        issue_open(TIME_W'(1), SER_W'(1234));
        issue_close('0);
        // Serial 7 is stored twice; the earlier time must go first.
        issue_close(SER_W'(7));
        issue_close(SER_W'(7));
        issue_close(SER_W'(9));
        issue_close(SER_W'(8));
        issue_close({SER_W{1'b1}});
    endtask

    task automatic test_random_traffic(input int n_items, input int tie_pct);
        int n;
        int live;
        int open_pct;
        int r;
        logic [TIME_W-1:0] t;
        logic [SER_W-1:0] s;
        for (n = 0; n < n_items; n++) begin
            live = open_serials.size();
            if (live < 3)
                open_pct = 85;
            else if (live > 13)
                open_pct = 25;
            else
                open_pct = 55;
            if ($urandom_range(0, 99) < open_pct) begin
                r = $urandom_range(0, 9);
                if (r < tie_pct) begin
                    t = TIME_W'($urandom_range(0, 7));
                end
                else if (r == 9) begin
                    case ($urandom_range(0, 2))
                        0: t = '0;
                        1: t = NONE_TIME;
                        default: t = NONE_TIME - TIME_W'(1);
                    endcase
                end
                else begin
                    t = TIME_W'($urandom);
                end
                if ($urandom_range(0, 19) == 0 && live > 0)
                    s = open_serials[$urandom_range(0, live - 1)];
                else
                    s = SER_W'($urandom);
                if (s == '0)
                    s = SER_W'(1);
                issue_open(t, s);
            end
            else begin
                r = $urandom_range(0, 19);
                if (r == 0)
                    s = '0;
                else if (r == 1 || live == 0)
                    s = SER_W'($urandom);
                else
                    s = open_serials[$urandom_range(0, live - 1)];
                issue_close(s);
            end
        end
    endtask

    // The result side holds off for a long stretch while requests keep coming.
    task automatic test_output_backpressure();
        idle_enable = 1'b0;
        hold_requests++;
        test_random_traffic(60, 3);
        wait_all_results();
        idle_enable = 1'b1;
    endtask

    task automatic test_back_to_back();
        idle_enable = 1'b0;
        test_random_traffic(400, 3);
        idle_enable = 1'b1;
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_order_and_ties();
        test_full_table();
        wait_all_results();
        test_random_traffic(600, 3);
        test_output_backpressure();
        test_back_to_back();
        test_random_traffic(600, 6);

        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && awaited_replies.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
